>>> rtl/lpad_pkg.sv
// Shared types and constants for the lookahead pair anomaly detector.
// No dependencies; imported by every module of the block.
package lpad_pkg;

	localparam int WINDOW_LENGTH = 9;
	localparam int NUM_CALLS     = 512;
	localparam int CALL_W        = $clog2(NUM_CALLS);
	localparam int ADDR_W        = 2 * CALL_W;
	localparam int SLOT_W        = $clog2(WINDOW_LENGTH + 1);
	localparam int MISM_W        = 4;
	localparam int TIME_W        = 56;
	localparam int CNT_W         = 32;
	localparam int FACT_W        = 16;
	localparam int ENTRY_W       = 8;
	localparam int CFG_IDX_W     = 2;

	// register indexes of the configuration port
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_NORMAL_WAIT   = 2'd0,
		CFG_NORMAL_FACTOR = 2'd1,
		CFG_FACTOR_DEN    = 2'd2,
		CFG_ANOMALY_LIMIT = 2'd3
	} cfg_idx_t;

	// one window slot
	typedef struct packed {
		logic              valid;
		logic [CALL_W-1:0] call;
	} slot_t;

	// table port controls from the sequencer
	typedef struct packed {
		logic               we;
		logic [ADDR_W-1:0]  waddr;
		logic [ENTRY_W-1:0] wdata;
		logic               re;
		logic [ADDR_W-1:0]  raddr;
	} tbl_ctl_t;

endpackage

>>> rtl/lpad_cell.sv
// One slot of the call window chain: holds a call and its valid bit.
// Depends on lpad_pkg.
module lpad_cell import lpad_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  shift,
	input  logic  clear,
	input  slot_t prev,
	output slot_t slot
);

	slot_t slot_q;

	// take the neighbor's slot on a shift, drop everything on clear
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
		end else if (clear) begin
			slot_q <= '0;
		end else if (shift) begin
			slot_q <= prev;
		end
	end

	assign slot = slot_q;

endmodule

>>> rtl/lpad_table.sv
// Lookahead pair table: one write port and one registered read port.
// Depends on lpad_pkg.
module lpad_table import lpad_pkg::*; (
	input  logic               clk,
	input  tbl_ctl_t           ctl,
	output logic [ENTRY_W-1:0] rdata
);

	logic [ENTRY_W-1:0] mem [2**ADDR_W];

	// write and read the pair entries
	always_ff @(posedge clk) begin
		if (ctl.we) begin
			mem[ctl.waddr] <= ctl.wdata;
		end
		if (ctl.re) begin
			rdata <= mem[ctl.raddr];
		end
	end

endmodule

>>> rtl/lookahead_pair_anomaly_detector_top.sv
// Sequence: a lookup pass reads the table for each checked slot, and a learning
// pass then writes the pair of each slot when the lookup found mismatches.
// Flow: one item at a time; a new input beat is taken only after the result of the
// last one has been loaded, and that load waits while the result side stalls.
// Reset: asynchronous, active low; afterwards a clearing pass zeroes all 262144
// pair table entries while input beats are held off (config still taken).
// Depends on lpad_pkg, lpad_cell and lpad_table.
module lookahead_pair_anomaly_detector_top import lpad_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [71:0] s_axis_tdata,  // syscall_number[8:0], now_time[64:9], zero pad
	input  logic        s_axis_tlast,  // process_exit
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,  // mismatch_count[3:0], anomalous[4],
	                                   // normal_mode[5], frozen_flag[6],
	                                   // anomaly_total[38:7], zero pad
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [55:0] cfg_data
);

	typedef enum logic [3:0] {
		ST_CLR, ST_IDLE, ST_READ, ST_RCHK, ST_UPD, ST_LREAD, ST_LWR,
		ST_FRZ1, ST_FRZ2, ST_FIN, ST_OUT
	} state_t;

	state_t state_q;

	logic [TIME_W-1:0] wait_q;
	logic [FACT_W-1:0] factor_q;
	logic [FACT_W-1:0] den_q;
	logic [CNT_W-1:0]  limit_q;

	logic [ADDR_W-1:0] clr_q;
	logic [SLOT_W-1:0] slot_q;
	logic [MISM_W-1:0] mism_q;
	logic [TIME_W-1:0] now_q;
	logic              exit_q;
	logic              was_normal_q;

	logic              normal_q;
	logic              frozen_q;
	logic [CNT_W-1:0]  train_q;
	logic [CNT_W-1:0]  slc_q;
	logic [CNT_W-1:0]  sum_q;
	logic [TIME_W-1:0] deadline_q;

	logic                     stable_nz_q;
	logic [CNT_W+FACT_W-1:0]  prod_den_q;
	logic [CNT_W+FACT_W-1:0]  prod_fac_q;

	logic              out_valid_q;
	logic [MISM_W-1:0] out_mism_q;
	logic              out_anom_q;
	logic              out_normal_q;
	logic              out_frozen_q;
	logic [CNT_W-1:0]  out_sum_q;

	slot_t             slots [WINDOW_LENGTH];
	slot_t             cur_slot;
	slot_t             head;
	logic              win_shift;
	logic              win_clear;
	logic              slot_live;
	logic [2:0]        bit_idx;
	logic [ENTRY_W-1:0] rdata;
	tbl_ctl_t          tctl;
	logic              accept;
	logic              can_load;
	logic [CNT_W-1:0]  stable;
	logic [TIME_W:0]   dl_sum;
	logic [CNT_W:0]    sum_add;
	logic [CNT_W:0]    train_add;
	logic [CNT_W:0]    slc_add;

	// window chain of cells, newest call in slot 0
	assign head.valid = 1'b1;
	assign head.call  = s_axis_tdata[CALL_W-1:0];

	generate
		for (genvar g = 0; g < WINDOW_LENGTH; g++) begin : g_cell
			if (g == 0) begin : g_head
				lpad_cell u_cell (
					.clk(clk), .arst_n(arst_n), .shift(win_shift), .clear(win_clear),
					.prev(head), .slot(slots[g])
				);
			end else begin : g_body
				lpad_cell u_cell (
					.clk(clk), .arst_n(arst_n), .shift(win_shift), .clear(win_clear),
					.prev(slots[g-1]), .slot(slots[g])
				);
			end
		end
	endgenerate

	// select the slot under test
	always_comb begin
		cur_slot = '0;
		for (int k = 0; k < WINDOW_LENGTH; k++) begin
			if (slot_q == SLOT_W'(k)) cur_slot = slots[k];
		end
	end

	assign slot_live = (slot_q < SLOT_W'(WINDOW_LENGTH)) && cur_slot.valid;
	assign bit_idx   = 3'(slot_q - SLOT_W'(1));

	lpad_table u_table (.clk(clk), .ctl(tctl), .rdata(rdata));

	// drive the table port from the sequencer state
	always_comb begin
		tctl       = '0;
		tctl.raddr = {slots[0].call, cur_slot.call};
		tctl.waddr = {slots[0].call, cur_slot.call};
		case (state_q)
			ST_CLR: begin
				tctl.we    = 1'b1;
				tctl.waddr = clr_q;
				tctl.wdata = '0;
			end
			ST_READ, ST_LREAD: begin
				tctl.re = slot_live;
			end
			ST_LWR: begin
				tctl.we    = 1'b1;
				tctl.wdata = rdata | (ENTRY_W'(1) << bit_idx);
			end
			default: begin
				tctl.we = 1'b0;
			end
		endcase
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign can_load      = !out_valid_q || m_axis_tready;
	assign win_shift     = accept;
	assign win_clear     = (state_q == ST_OUT) && can_load && exit_q;
	assign cfg_ready     = 1'b1;

	assign stable    = (train_q >= slc_q) ? (train_q - slc_q) : '0;
	assign dl_sum    = {1'b0, now_q} + {1'b0, wait_q};
	assign sum_add   = {1'b0, sum_q} + (CNT_W+1)'(mism_q);
	assign train_add = {1'b0, train_q} + (CNT_W+1)'(1);
	assign slc_add   = {1'b0, slc_q} + (CNT_W+1)'(1);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wait_q   <= TIME_W'(604800000000000);
			factor_q <= FACT_W'(128);
			den_q    <= FACT_W'(32);
			limit_q  <= CNT_W'(30);
		end else if (cfg_valid) begin
			case (cfg_idx_t'(cfg_index))
				CFG_NORMAL_WAIT:   wait_q   <= cfg_data;
				CFG_NORMAL_FACTOR: factor_q <= cfg_data[FACT_W-1:0];
				CFG_FACTOR_DEN:    den_q    <= cfg_data[FACT_W-1:0];
				CFG_ANOMALY_LIMIT: limit_q  <= cfg_data[CNT_W-1:0];
				default:           limit_q  <= limit_q;
			endcase
		end
	end

	// sequencer, profile state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLR;
			clr_q        <= '0;
			slot_q       <= '0;
			mism_q       <= '0;
			exit_q       <= 1'b0;
			was_normal_q <= 1'b0;
			normal_q     <= 1'b0;
			frozen_q     <= 1'b0;
			train_q      <= '0;
			slc_q        <= '0;
			sum_q        <= '0;
			deadline_q   <= '0;
			stable_nz_q  <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			// drop the result once taken, unless a new one loads now
			if (out_valid_q && m_axis_tready && state_q != ST_OUT) out_valid_q <= 1'b0;
			case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + ADDR_W'(1);
					if (clr_q == '1) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (accept) begin
						now_q        <= s_axis_tdata[CALL_W+TIME_W-1:CALL_W];
						exit_q       <= s_axis_tlast;
						was_normal_q <= normal_q;
						mism_q       <= '0;
						slot_q       <= SLOT_W'(1);
						state_q      <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= slot_live ? ST_RCHK : ST_UPD;
				end
				ST_RCHK: begin
					if (!rdata[bit_idx]) mism_q <= mism_q + MISM_W'(1);
					slot_q  <= slot_q + SLOT_W'(1);
					state_q <= ST_READ;
				end
				ST_UPD: begin
					// detection, then the training count
					if (normal_q && mism_q != '0) begin
						if (sum_q > limit_q) normal_q <= 1'b0;
						sum_q <= sum_add[CNT_W] ? '1 : sum_add[CNT_W-1:0];
					end
					train_q <= train_add[CNT_W] ? '1 : train_add[CNT_W-1:0];
					if (mism_q != '0) begin
						frozen_q <= 1'b0;
						slc_q    <= '0;
						slot_q   <= SLOT_W'(1);
						state_q  <= ST_LREAD;
					end else begin
						slc_q   <= slc_add[CNT_W] ? '1 : slc_add[CNT_W-1:0];
						state_q <= frozen_q ? ST_FIN : ST_FRZ1;
					end
				end
				ST_LREAD: begin
					state_q <= slot_live ? ST_LWR : ST_FIN;
				end
				ST_LWR: begin
					slot_q  <= slot_q + SLOT_W'(1);
					state_q <= ST_LREAD;
				end
				ST_FRZ1: begin
					stable_nz_q <= (stable != '0);
					prod_den_q  <= train_q * den_q;
					prod_fac_q  <= stable * factor_q;
					state_q     <= ST_FRZ2;
				end
				ST_FRZ2: begin
					if (stable_nz_q && prod_den_q > prod_fac_q) begin
						frozen_q   <= 1'b1;
						deadline_q <= dl_sum[TIME_W] ? '1 : dl_sum[TIME_W-1:0];
					end
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (frozen_q && now_q > deadline_q) begin
						normal_q <= 1'b1;
						frozen_q <= 1'b0;
						sum_q    <= '0;
						slc_q    <= '0;
					end
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (can_load) begin
						out_valid_q  <= 1'b1;
						out_mism_q   <= mism_q;
						out_anom_q   <= was_normal_q && (mism_q != '0);
						out_normal_q <= normal_q;
						out_frozen_q <= frozen_q;
						out_sum_q    <= sum_q;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {1'b0, out_sum_q, out_frozen_q, out_normal_q, out_anom_q,
	                        out_mism_q};

`ifndef SYNTHESIS
	a_anom_needs_mism: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_anom_q) |-> (out_mism_q != '0))
		else $error("anomalous result without mismatches");
	a_mism_bound: assert property (@(posedge clk) disable iff (!arst_n)
		mism_q <= MISM_W'(WINDOW_LENGTH - 1))
		else $error("mismatch count beyond window");
	a_learn_only_on_mism: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LWR) |-> (mism_q != '0))
		else $error("table learn without mismatch");
	a_no_accept_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLR) |=> !$past(accept))
		else $error("input taken during table clear");
`endif

endmodule

>>> test/testbench.sv
// Self-checking testbench for lookahead_pair_anomaly_detector_top.
// Mirrors the pair table and profile state in a local model and checks every result beat.
// Depends on lpad_pkg and the RTL of the block.
module testbench;
	import lpad_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam bit [63:0] MAX32 = 64'hFFFF_FFFF;
	localparam bit [63:0] MAX56 = 64'h00FF_FFFF_FFFF_FFFF;
	localparam int LIMIT_CYCLES = 3_000_000;

	// fields from the lowest bit up: mism, anom, nrm, frz, total
	typedef struct packed {
		logic [31:0] total;
		logic        frz;
		logic        nrm;
		logic        anom;
		logic [3:0]  mism;
	} verdict_t;

	typedef struct {
		bit [8:0]  call;
		bit [55:0] now;
		bit        leave;
		bit        typed;
		verdict_t  want;
	} row_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [71:0] s_axis_tdata;
	logic        s_axis_tlast;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [39:0] m_axis_tdata;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [55:0] cfg_data;

	lookahead_pair_anomaly_detector_top dut (.*);

	// model copy of configuration and profile
	bit [63:0] m_wait, m_fac, m_den, m_lim;
	bit [8:0]  win_call [WINDOW_LENGTH];
	bit        win_ok [WINDOW_LENGTH];
	bit [7:0]  pairs [NUM_CALLS*NUM_CALLS];
	bit        m_normal, m_frozen;
	bit [63:0] m_train, m_since, m_anom, m_deadline;

	verdict_t  pending [$];
	int        errors = 0;
	int        results_seen = 0;
	int        cycles = 0;
	bit        quiet = 0;
	bit [55:0] clock_ns = 0;
	int        normal_hits = 0;

	function automatic bit [63:0] sat32(bit [63:0] a, bit [63:0] b);
		bit [63:0] s;
		s = a + b;
		return (s > MAX32) ? MAX32 : s;
	endfunction

	// advance the model by one call and return the expected beat
	function automatic verdict_t detect_step(bit [8:0] call, bit [55:0] now, bit leave);
		verdict_t v;
		bit        was_normal;
		int        mism;
		bit [63:0] stable, dl;
		was_normal = m_normal;
		mism = 0;
		for (int i = WINDOW_LENGTH - 1; i > 0; i--) begin
			win_call[i] = win_call[i-1];
			win_ok[i] = win_ok[i-1];
		end
		win_call[0] = call;
		win_ok[0] = 1;
		for (int i = 1; i < WINDOW_LENGTH; i++) begin
			if (!win_ok[i]) break;
			if (pairs[{win_call[0], win_call[i]}][i-1] == 0) mism++;
		end
		if (m_normal && mism != 0) begin
			if (m_anom > m_lim) m_normal = 0;
			m_anom = sat32(m_anom, 64'(mism));
		end
		m_train = sat32(m_train, 1);
		if (mism != 0) begin
			m_frozen = 0;
			for (int i = 1; i < WINDOW_LENGTH; i++) begin
				if (!win_ok[i]) break;
				pairs[{win_call[0], win_call[i]}][i-1] = 1;
			end
			m_since = 0;
		end else begin
			m_since = sat32(m_since, 1);
			if (!m_frozen) begin
				stable = (m_train >= m_since) ? m_train - m_since : 0;
				if (stable > 0 && m_train * m_den > stable * m_fac) begin
					dl = {8'd0, now} + m_wait;
					m_frozen = 1;
					m_deadline = (dl > MAX56) ? MAX56 : dl;
				end
			end
		end
		if (m_frozen && now > m_deadline) begin
			m_normal = 1;
			m_frozen = 0;
			m_anom = 0;
			m_since = 0;
			normal_hits++;
		end
		v.mism = mism[3:0];
		v.anom = was_normal && mism != 0;
		v.nrm = m_normal;
		v.frz = m_frozen;
		v.total = m_anom[31:0];
		if (leave) begin
			for (int i = 0; i < WINDOW_LENGTH; i++) begin
				win_call[i] = 0;
				win_ok[i] = 0;
			end
		end
		return v;
	endfunction

	// clock
	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("Timeout after %0d cycles", cycles);
			$display("Mismatches found");
			$finish;
		end
	end

	// result side: random back-pressure
	initial begin
		m_axis_tready = 0;
		forever begin
			@(negedge clk);
			m_axis_tready = quiet ? 1'b1 : ($urandom_range(99) >= 14);
		end
	end

	// compare each result beat with the oldest expectation
	always @(posedge clk) begin
		verdict_t got, exp_v;
		if (m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata[38:0];
			results_seen++;
			if (pending.size() == 0) begin
				$error("result beat with nothing expected: %h", got);
				errors++;
			end else begin
				exp_v = pending.pop_front();
				if (got.mism !== exp_v.mism) begin
					$error("mismatch_count exp %0d got %0d", exp_v.mism, got.mism);
					errors++;
				end
				if (got.anom !== exp_v.anom) begin
					$error("anomalous exp %0d got %0d", exp_v.anom, got.anom);
					errors++;
				end
				if (got.nrm !== exp_v.nrm) begin
					$error("normal_mode exp %0d got %0d", exp_v.nrm, got.nrm);
					errors++;
				end
				if (got.frz !== exp_v.frz) begin
					$error("frozen_flag exp %0d got %0d", exp_v.frz, got.frz);
					errors++;
				end
				if (got.total !== exp_v.total) begin
					$error("anomaly_total exp %0d got %0d", exp_v.total, got.total);
					errors++;
				end
			end
		end
	end

	task automatic write_reg(cfg_idx_t idx, bit [55:0] val);
		@(negedge clk);
		cfg_valid = 1;
		cfg_index = idx;
		cfg_data = val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_NORMAL_WAIT:   m_wait = val;
			CFG_NORMAL_FACTOR: m_fac = val[15:0];
			CFG_FACTOR_DEN:    m_den = val[15:0];
			CFG_ANOMALY_LIMIT: m_lim = val[31:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 0;
	endtask

	// send one beat; a typed expectation replaces the model output
	task automatic send_call(bit [8:0] call, bit [55:0] now, bit leave,
			bit typed, verdict_t want);
		verdict_t v;
		while (!quiet && $urandom_range(99) < 14) begin
			s_axis_tvalid = 0;
			@(negedge clk);
		end
		s_axis_tvalid = 1;
		s_axis_tdata = {7'd0, now, call};
		s_axis_tlast = leave;
		do @(posedge clk); while (!s_axis_tready);
		v = detect_step(call, now, leave);
		pending.push_back(typed ? want : v);
		@(negedge clk);
		s_axis_tvalid = 0;
	endtask

	// hold off until every expected beat is back, then let the pipe drain
	task automatic drain();
		while (pending.size() != 0) @(negedge clk);
		repeat (50) @(negedge clk);
	endtask

	task automatic random_run(int count);
		bit [8:0] loop_calls [12];
		int       loop_len, pos;
		bit [8:0] c;
		loop_len = $urandom_range(12, 2);
		for (int i = 0; i < 12; i++) loop_calls[i] = $urandom_range(7);
		pos = 0;
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(99) < 82) begin
				c = loop_calls[pos];
				pos = (pos + 1) % loop_len;
			end else begin
				c = $urandom_range(511);
			end
			if ($urandom_range(199) == 0) begin
				loop_len = $urandom_range(12, 2);
				for (int i = 0; i < 12; i++) loop_calls[i] = $urandom_range(7);
			end
			clock_ns += $urandom_range(2000);
			send_call(c, clock_ns, $urandom_range(99) < 3, 0, '0);
		end
	endtask

	row_t rows [$];

	initial begin
		row_t r;
		s_axis_tvalid = 0;
		s_axis_tdata = '0;
		s_axis_tlast = 0;
		cfg_valid = 0;
		cfg_index = CFG_NORMAL_WAIT;
		cfg_data = '0;
		m_wait = 64'd604800000000000;
		m_fac = 128;
		m_den = 32;
		m_lim = 30;
		arst_n = 0;
		repeat (5) @(negedge clk);
		arst_n = 1;

		// directed rows: first two after reset are typed out
		r = '{call: 9'd0, now: 56'd0, leave: 0, typed: 1, want: '0};
		rows.push_back(r);
		r = '{call: 9'd511, now: 56'd0, leave: 0, typed: 1,
			want: '{mism: 4'd1, anom: 0, nrm: 0, frz: 0, total: 0}};
		rows.push_back(r);
		for (int i = 0; i < 10; i++) begin
			r = '{call: 9'(i % 3), now: 56'(10 + i), leave: (i == 9), typed: 0, want: '0};
			rows.push_back(r);
		end
		for (int i = 0; i < 10; i++) begin
			r = '{call: 9'(i % 2 ? 511 : 1), now: 56'(100 + i), leave: 0, typed: 0,
				want: '0};
			rows.push_back(r);
		end
		foreach (rows[k])
			send_call(rows[k].call, rows[k].now, rows[k].leave, rows[k].typed,
				rows[k].want);
		clock_ns = 200;
		random_run(250);
		drain();

		// quick normal mode entry, zero limit
		write_reg(CFG_NORMAL_WAIT, 56'd1000);
		write_reg(CFG_NORMAL_FACTOR, 56'd1);
		write_reg(CFG_FACTOR_DEN, 56'd1);
		write_reg(CFG_ANOMALY_LIMIT, 56'd0);
		quiet = 1;
		random_run(300);
		quiet = 0;
		drain();

		// top extremes, deadline saturates
		write_reg(CFG_NORMAL_WAIT, MAX56[55:0]);
		write_reg(CFG_NORMAL_FACTOR, 56'hFFFF);
		write_reg(CFG_FACTOR_DEN, 56'hFFFF);
		write_reg(CFG_ANOMALY_LIMIT, 56'hFFFF_FFFF);
		random_run(250);
		drain();

		// zero wait, small limit, defaults ratio
		write_reg(CFG_NORMAL_WAIT, 56'd0);
		write_reg(CFG_NORMAL_FACTOR, 56'd128);
		write_reg(CFG_FACTOR_DEN, 56'd32);
		write_reg(CFG_ANOMALY_LIMIT, 56'd5);
		random_run(300);
		drain();

		// random settings with small waits
		for (int p = 0; p < 2; p++) begin
			write_reg(CFG_NORMAL_WAIT, 56'($urandom_range(5000)));
			write_reg(CFG_NORMAL_FACTOR, 56'($urandom_range(65535, 1)));
			write_reg(CFG_FACTOR_DEN, 56'($urandom_range(65535, 1)));
			write_reg(CFG_ANOMALY_LIMIT, 56'($urandom_range(60)));
			random_run(300);
			drain();
		end

		// times near the top of the range
		write_reg(CFG_NORMAL_WAIT, 56'd3000);
		clock_ns = MAX56[55:0] - 56'd400000 - 56'($urandom_range(1000));
		random_run(150);
		drain();

		$display("Covered %0d result beats over seven register settings, %0d entries to normal mode.",
			results_seen, normal_hits);
		if (errors == 0 && pending.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule
